// ===== src/edf_pkg.sv =====
`default_nettype none

package edf_pkg;

    localparam int MAX_JOBS = 64;
    localparam int DAY_BITS = 16;
    localparam int ID_BITS  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_BITS = $clog2(MAX_JOBS + 1);

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic KIND_ASSIGN  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/edf_ifs.sv =====
`default_nettype none

// Job transaction channel.
interface edf_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [edf_pkg::DAY_BITS-1:0]  release_day;
    logic [edf_pkg::DAY_BITS-1:0]  deadline_day;
    logic [edf_pkg::DAY_BITS-1:0]  duration;

    modport source (output valid, action, release_day, deadline_day, duration,
                    input ready);
    modport sink   (input valid, action, release_day, deadline_day, duration,
                    output ready);
endinterface

// Result transaction channel.
interface edf_out_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [edf_pkg::DAY_BITS-1:0]  day_number;
    logic [edf_pkg::CNT_BITS-1:0]  job_number;
    logic                          deadline_missed;
    logic                          feasible;

    modport source (output valid, result_kind, day_number, job_number,
                    deadline_missed, feasible, input ready);
    modport sink   (input valid, result_kind, day_number, job_number,
                    deadline_missed, feasible, output ready);
endinterface

// Configuration write channel: day limit register.
interface edf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [edf_pkg::DAY_BITS-1:0]  day_limit;

    modport source (output valid, day_limit, input ready);
    modport sink   (input valid, day_limit, output ready);
endinterface

`default_nettype wire

// ===== src/edf_unit_slot_scheduler_core.sv =====
`default_nettype none

// Earliest-deadline-first scheduler for unit day slots. A load transaction
// (action 0) stores a job's release day, deadline and duration under the next
// id (1, 2, ...); a load past the table capacity is dropped and sets the
// sticky failure. A tick transaction (action 1) advances the day and walks
// the job table once through a single comparator, one entry per cycle from
// the table's registered read port, to find the released unfinished job with
// the earliest deadline (ties to the smaller id). After the walk, the update
// state charges the slot to that job and the emit state hands the result to
// the output register, waiting there while the output is blocked. The input
// is ready again in the same cycle as the result goes valid. Ticks at or past
// the day limit or on the last day of the range, and action 3, are dropped
// with no result. A finish transaction (action 2) passes through the emit
// state to the output register with the verdict, from a running count of
// unfinished jobs and the sticky failure, and the input is ready again with
// the result. The input is ready only while no transaction is in progress; the
// output register holds one result, so a new transaction is taken while the
// last result still waits downstream. The day limit register may be written at
// any time the block is idle; it resets to zero, which makes every tick a no-op.
module edf_unit_slot_scheduler_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    edf_cfg_if.sink      i_cfg,
    edf_in_if.sink       i_job,
    edf_out_if.source    o_res
);

    localparam int ID_BITS  = edf_pkg::ID_BITS;
    localparam int CNT_BITS = edf_pkg::CNT_BITS;
    localparam int DAY_BITS = edf_pkg::DAY_BITS;

    // Job table: one entry per loaded job, written on load, remaining also on
    // each charged slot. Read data is registered.
    logic [DAY_BITS-1:0] mem_rel [edf_pkg::MAX_JOBS];
    logic [DAY_BITS-1:0] mem_dl  [edf_pkg::MAX_JOBS];
    logic [DAY_BITS-1:0] mem_rem [edf_pkg::MAX_JOBS];

    edf_pkg::t_state r_state, n_state;

    logic [DAY_BITS-1:0] r_day_limit;
    logic [DAY_BITS-1:0] r_day, n_day;
    logic [CNT_BITS-1:0] r_total, n_total;
    logic [CNT_BITS-1:0] r_unfinished, n_unfinished;
    logic                r_failed, n_failed;

    // Scan pipeline: issue address, then compare the registered entry.
    logic [CNT_BITS-1:0] r_idx, n_idx;
    logic                r_chk, n_chk;
    logic [ID_BITS-1:0]  r_chk_idx, n_chk_idx;
    logic                r_found, n_found;
    logic [ID_BITS-1:0]  r_best_idx, n_best_idx;
    logic [DAY_BITS-1:0] r_best_dl, n_best_dl;
    logic [DAY_BITS-1:0] r_best_rem, n_best_rem;

    // Pending result, moved to the output register when it is free.
    logic                r_pend_kind, n_pend_kind;
    logic [CNT_BITS-1:0] r_pend_job, n_pend_job;
    logic                r_pend_ok, n_pend_ok;

    logic                r_out_valid, n_out_valid;
    logic                r_out_kind, n_out_kind;
    logic [DAY_BITS-1:0] r_out_day, n_out_day;
    logic [CNT_BITS-1:0] r_out_job, n_out_job;
    logic                r_out_missed, n_out_missed;
    logic                r_out_ok, n_out_ok;

    logic [DAY_BITS-1:0] r_rd_rel, r_rd_dl, r_rd_rem;
    logic [ID_BITS-1:0]  rd_addr;

    logic                wr_ld_en;
    logic                wr_rem_en;
    logic [ID_BITS-1:0]  wr_addr;
    logic [DAY_BITS-1:0] wr_rem;

    logic                job_acc;
    logic                out_free;
    logic                issue;
    logic                take;

    assign i_cfg.ready = 1'b1;
    assign i_job.ready = (r_state == edf_pkg::S_IDLE);
    assign job_acc     = i_job.valid && i_job.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_out_kind;
    assign o_res.day_number      = r_out_day;
    assign o_res.job_number      = r_out_job;
    assign o_res.deadline_missed = r_out_missed;
    assign o_res.feasible        = r_out_ok;

    assign rd_addr = r_idx[ID_BITS-1:0];
    assign issue   = (r_idx < r_total);

    // Shared compare unit: released, unfinished, strictly earlier deadline.
    assign take = (r_rd_rem != '0) && (r_rd_rel <= r_day)
               && (!r_found || (r_rd_dl < r_best_dl));

    always_comb begin
        n_state      = r_state;
        n_day        = r_day;
        n_total      = r_total;
        n_unfinished = r_unfinished;
        n_failed     = r_failed;
        n_idx        = r_idx;
        n_chk        = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_dl    = r_best_dl;
        n_best_rem   = r_best_rem;
        n_pend_kind  = r_pend_kind;
        n_pend_job   = r_pend_job;
        n_pend_ok    = r_pend_ok;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_day    = r_out_day;
        n_out_job    = r_out_job;
        n_out_missed = r_out_missed;
        n_out_ok     = r_out_ok;
        wr_ld_en     = 1'b0;
        wr_rem_en    = 1'b0;
        wr_addr      = r_total[ID_BITS-1:0];
        wr_rem       = i_job.duration;

        unique case (r_state)
            edf_pkg::S_IDLE: begin
                if (job_acc) begin
                    unique case (i_job.action)
                        edf_pkg::ACT_LOAD: begin
                            if (r_total >= CNT_BITS'(edf_pkg::MAX_JOBS)) begin
                                n_failed = 1'b1;
                            end else begin
                                wr_ld_en  = 1'b1;
                                wr_rem_en = 1'b1;
                                n_total   = r_total + CNT_BITS'(1);
                                if (i_job.duration != '0) begin
                                    n_unfinished = r_unfinished + CNT_BITS'(1);
                                end
                            end
                        end
                        edf_pkg::ACT_TICK: begin
                            // Drop ticks at the limit or at the top of the day range.
                            if ((r_day < r_day_limit) && (r_day != '1)) begin
                                n_day   = r_day + DAY_BITS'(1);
                                n_idx   = '0;
                                n_found = 1'b0;
                                n_state = edf_pkg::S_SCAN;
                            end
                        end
                        edf_pkg::ACT_FINISH: begin
                            n_pend_kind = edf_pkg::KIND_VERDICT;
                            n_pend_job  = '0;
                            n_pend_ok   = !r_failed && (r_unfinished == '0);
                            n_state     = edf_pkg::S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            edf_pkg::S_SCAN: begin
                if (issue) begin
                    n_idx     = r_idx + CNT_BITS'(1);
                    n_chk     = 1'b1;
                    n_chk_idx = rd_addr;
                end
                if (r_chk && take) begin
                    n_found    = 1'b1;
                    n_best_idx = r_chk_idx;
                    n_best_dl  = r_rd_dl;
                    n_best_rem = r_rd_rem;
                end
                if (!issue && !r_chk) begin
                    n_state = edf_pkg::S_UPDATE;
                end
            end
            edf_pkg::S_UPDATE: begin
                n_pend_kind = edf_pkg::KIND_ASSIGN;
                n_pend_ok   = 1'b0;
                n_pend_job  = '0;
                if (r_found) begin
                    wr_rem_en  = 1'b1;
                    wr_addr    = r_best_idx;
                    wr_rem     = r_best_rem - DAY_BITS'(1);
                    n_pend_job = CNT_BITS'(r_best_idx) + CNT_BITS'(1);
                    if (r_best_dl < r_day) begin
                        n_failed = 1'b1;
                    end
                    if (r_best_rem == DAY_BITS'(1)) begin
                        n_unfinished = r_unfinished - CNT_BITS'(1);
                    end
                end
                n_state = edf_pkg::S_EMIT;
            end
            edf_pkg::S_EMIT: begin
                // Hold the result until the output register frees up.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_day    = r_day;
                    n_out_job    = r_pend_job;
                    n_out_missed = r_failed;
                    n_out_ok     = r_pend_ok;
                    n_state      = edf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = edf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= edf_pkg::S_IDLE;
            r_day_limit  <= '0;
            r_day        <= '0;
            r_total      <= '0;
            r_unfinished <= '0;
            r_failed     <= 1'b0;
            r_idx        <= '0;
            r_chk        <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_day_limit <= i_cfg.day_limit;
            end
            r_day        <= n_day;
            r_total      <= n_total;
            r_unfinished <= n_unfinished;
            r_failed     <= n_failed;
            r_idx        <= n_idx;
            r_chk        <= n_chk;
            r_found      <= n_found;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_best_idx   <= n_best_idx;
        r_best_dl    <= n_best_dl;
        r_best_rem   <= n_best_rem;
        r_pend_kind  <= n_pend_kind;
        r_pend_job   <= n_pend_job;
        r_pend_ok    <= n_pend_ok;
        r_out_kind   <= n_out_kind;
        r_out_day    <= n_out_day;
        r_out_job    <= n_out_job;
        r_out_missed <= n_out_missed;
        r_out_ok     <= n_out_ok;
    end

    // Job table write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_ld_en) begin
            mem_rel[wr_addr] <= i_job.release_day;
            mem_dl[wr_addr]  <= i_job.deadline_day;
        end
        if (wr_rem_en) begin
            mem_rem[wr_addr] <= wr_rem;
        end
        r_rd_rel <= mem_rel[rd_addr];
        r_rd_dl  <= mem_dl[rd_addr];
        r_rd_rem <= mem_rem[rd_addr];
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total <= CNT_BITS'(edf_pkg::MAX_JOBS)) && (r_unfinished <= r_total))
        else $error("job counters out of range");

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("failure flag cleared");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == edf_pkg::S_SCAN) |-> (r_idx <= r_total))
        else $error("scan index past job count");

    a_pick_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == edf_pkg::S_UPDATE && r_found) |->
            (CNT_BITS'(r_best_idx) < r_total) && (r_best_rem != '0))
        else $error("chosen job not a live table entry");

    a_day_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == edf_pkg::S_IDLE && job_acc && i_job.action == edf_pkg::ACT_TICK
            && r_day < r_day_limit) |=> (r_day == $past(r_day) + DAY_BITS'(1)))
        else $error("day did not advance on tick");

endmodule

`default_nettype wire

// ===== tb/edf_unit_slot_scheduler_core_test.sv =====
`timescale 1ns / 1ps

module edf_unit_slot_scheduler_core_test;

    localparam int MAX_JOBS = edf_pkg::MAX_JOBS;
    localparam int DAY_BITS = edf_pkg::DAY_BITS;
    localparam int CNT_BITS = edf_pkg::CNT_BITS;

    // Action 3 has no name in the package; the block must drop it silently.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int                  CLK_HALF      = 10;
    localparam int                  CYCLE_LIMIT   = 1_000_000;
    // Settle time covers a tick with a full table, with margin on top.
    localparam int                  SETTLE_CYCLES = 100;
    localparam int                  ITEM_TARGET   = 1900;
    localparam logic [DAY_BITS-1:0] DAY_MAX       = '1;

    typedef struct packed {
        logic [1:0]          action;
        logic [DAY_BITS-1:0] release_day;
        logic [DAY_BITS-1:0] deadline_day;
        logic [DAY_BITS-1:0] duration;
    } job_req_t;

    typedef struct packed {
        logic                kind;
        logic [DAY_BITS-1:0] day;
        logic [CNT_BITS-1:0] job;
        logic                missed;
        logic                feasible;
    } slot_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    edf_cfg_if cfg_if ();
    edf_in_if  job_if ();
    edf_out_if res_if ();

    edf_unit_slot_scheduler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_job   (job_if),
        .o_res   (res_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copy of the scheduler: job table, day counter, sticky failure and
    // the day limit register.
    logic [DAY_BITS-1:0] sched_release   [MAX_JOBS];
    logic [DAY_BITS-1:0] sched_deadline  [MAX_JOBS];
    logic [DAY_BITS-1:0] sched_remaining [MAX_JOBS];
    int                  sched_total     = 0;
    logic [DAY_BITS-1:0] sched_day       = '0;
    logic                sched_failed    = 1'b0;
    logic [DAY_BITS-1:0] sched_limit     = '0;

    // Results predicted but not yet seen on the output channel, oldest first.
    slot_result_t slot_results_due [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // Receiver stall pattern state.
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    // ------------------------------------------------------------------
    // Watchdog: end the run if the block hangs or drops a result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switch at random between always ready, coin-flip ready and
    // mostly ready with long stalls.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(200, 1000);
        end
        mode_left = mode_left - 1;
        case (ready_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    stall_left = stall_left - 1;
                    res_if.ready <= 1'b0;
                end else if ($urandom_range(0, 19) == 0) begin
                    stall_left = $urandom_range(1, 40);
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Checker: compare every accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        slot_result_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (slot_results_due.size() == 0) begin
                report_mismatch("unexpected result, day", int'(res_if.day_number), -1);
            end else begin
                want = slot_results_due.pop_front();
                if (res_if.result_kind !== want.kind)
                    report_mismatch("result_kind", res_if.result_kind, want.kind);
                if (res_if.day_number !== want.day)
                    report_mismatch("day_number", res_if.day_number, want.day);
                if (res_if.job_number !== want.job)
                    report_mismatch("job_number", res_if.job_number, want.job);
                if (res_if.deadline_missed !== want.missed)
                    report_mismatch("deadline_missed", res_if.deadline_missed, want.missed);
                if (res_if.feasible !== want.feasible)
                    report_mismatch("feasible", res_if.feasible, want.feasible);
            end
        end
    end

    // ------------------------------------------------------------------
    // Predictor: apply one accepted transaction to the shadow state and
    // queue the result it causes, if any.
    // ------------------------------------------------------------------
    task automatic edf_schedule_step(input job_req_t req);
        slot_result_t res;
        int           best;
        bit           found;
        bit           all_done;
        res = '0;
        case (req.action)
            edf_pkg::ACT_LOAD: begin
                // Drop a load into a full table, but remember it as a failure.
                if (sched_total >= MAX_JOBS) begin
                    sched_failed = 1'b1;
                end else begin
                    sched_release[sched_total]   = req.release_day;
                    sched_deadline[sched_total]  = req.deadline_day;
                    sched_remaining[sched_total] = req.duration;
                    sched_total++;
                end
            end
            edf_pkg::ACT_TICK: begin
                // Ignore ticks at or past the limit, or at the last day.
                if (sched_day < sched_limit && sched_day != DAY_MAX) begin
                    sched_day = sched_day + 1'b1;
                    best  = 0;
                    found = 1'b0;
                    for (int i = 0; i < sched_total; i++) begin
                        if (sched_remaining[i] != 0 && sched_release[i] <= sched_day) begin
                            // Strict compare keeps the smaller id on a tie.
                            if (!found || sched_deadline[i] < sched_deadline[best]) begin
                                best  = i;
                                found = 1'b1;
                            end
                        end
                    end
                    res.kind = edf_pkg::KIND_ASSIGN;
                    res.day  = sched_day;
                    if (found) begin
                        if (sched_deadline[best] < sched_day)
                            sched_failed = 1'b1;
                        sched_remaining[best] = sched_remaining[best] - 1'b1;
                        res.job = CNT_BITS'(best + 1);
                    end
                    res.missed = sched_failed;
                    slot_results_due.push_back(res);
                end
            end
            edf_pkg::ACT_FINISH: begin
                all_done = 1'b1;
                for (int i = 0; i < sched_total; i++) begin
                    if (sched_remaining[i] != 0)
                        all_done = 1'b0;
                end
                res.kind     = edf_pkg::KIND_VERDICT;
                res.day      = sched_day;
                res.missed   = sched_failed;
                res.feasible = !sched_failed && all_done;
                slot_results_due.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Send one transaction; valid stays high afterwards so a back-to-back
    // transaction can follow without a gap.
    task automatic send_job(input logic [1:0] act, input int rel_day, input int dl_day,
                            input int dur);
        job_req_t req;
        req.action       = act;
        req.release_day  = DAY_BITS'(rel_day);
        req.deadline_day = DAY_BITS'(dl_day);
        req.duration     = DAY_BITS'(dur);
        @(negedge i_clk);
        job_if.valid        <= 1'b1;
        job_if.action       <= req.action;
        job_if.release_day  <= req.release_day;
        job_if.deadline_day <= req.deadline_day;
        job_if.duration     <= req.duration;
        do @(posedge i_clk); while (!job_if.ready);
        items_sent++;
        edf_schedule_step(req);
    endtask

    // Hold the job channel idle for a number of cycles.
    task automatic pause_jobs(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            job_if.valid <= 1'b0;
        end
    endtask

    // Stop sending, wait for every predicted result, then let the block
    // finish any silent work for the given number of cycles.
    task automatic settle_block(input int tail);
        pause_jobs(1);
        while (slot_results_due.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_day_limit(input int limit);
        settle_block(SETTLE_CYCLES);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.day_limit <= DAY_BITS'(limit);
        do @(posedge i_clk); while (!cfg_if.ready);
        sched_limit = DAY_BITS'(limit);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic int clip_day(input int d);
        return (d > int'(DAY_MAX)) ? int'(DAY_MAX) : d;
    endfunction

    // Load a job whose window opens soon after the current day.
    task automatic load_near_job();
        int rel_day;
        rel_day = clip_day(int'(sched_day) + $urandom_range(0, 15));
        send_job(edf_pkg::ACT_LOAD, rel_day, clip_day(rel_day + $urandom_range(0, 40)),
                 $urandom_range(1, 6));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Limit is zero after reset: ticks and action 3 drop, finish still reports.
    task automatic test_reset_state();
        send_job(edf_pkg::ACT_TICK, 0, 0, 1);
        send_job(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_job(edf_pkg::ACT_FINISH, 0, 0, 1);
    endtask

    // Earliest deadline first, ties to the smaller id, idle days, the limit.
    task automatic test_edf_order();
        write_day_limit(10);
        send_job(edf_pkg::ACT_LOAD, 1, 5, 2);
        send_job(edf_pkg::ACT_LOAD, 0, 3, 1);
        send_job(edf_pkg::ACT_LOAD, 0, 3, 1);
        repeat (5) send_job(edf_pkg::ACT_TICK, 0, 0, 1);
        send_job(edf_pkg::ACT_FINISH, 0, 0, 1);
        // Run up to the limit, then one tick past it.
        repeat (6) send_job(edf_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_job(edf_pkg::ACT_FINISH, 0, 0, 1);
    endtask

    // A late job still gets its slot but the failure sticks.
    task automatic test_missed_deadline();
        write_day_limit(int'(DAY_MAX));
        send_job(edf_pkg::ACT_LOAD, 0, 0, 1);
        send_job(edf_pkg::ACT_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_job(edf_pkg::ACT_TICK, 0, 0, 1);
        send_job(edf_pkg::ACT_TICK, 0, 0, 1);
        send_job(edf_pkg::ACT_FINISH, 0, 0, 1);
        send_job(edf_pkg::ACT_FINISH, 0, 0, 1);
    endtask

    // Phases of mixed traffic, each under its own day limit.
    task automatic test_random_schedule();
        int  phase;
        int  n;
        int  limit;
        int  burst_left;
        int  pause_at;
        int  pick;
        bit  steady;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                1:       limit = 0;
                3:       limit = int'(DAY_MAX);
                default: limit = clip_day(int'(sched_day) + $urandom_range(0, 200));
            endcase
            write_day_limit(limit);
            n          = (phase == 1) ? 20 : $urandom_range(120, 260);
            steady     = ($urandom_range(0, 3) == 0);
            pause_at   = $urandom_range(0, n - 1);
            burst_left = $urandom_range(1, 16);
            for (int k = 0; k < n && items_sent < ITEM_TARGET; k++) begin
                // Hold off once per phase until the output side is empty.
                if (k == pause_at)
                    settle_block(0);
                if (burst_left == 0) begin
                    if (!steady)
                        pause_jobs($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    load_near_job();
                else if (pick < 8)
                    send_job(edf_pkg::ACT_LOAD, $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(1, 65535));
                else if (pick < 11)
                    send_job(edf_pkg::ACT_FINISH, $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(1, 65535));
                else if (pick < 13)
                    send_job(ACT_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(1, 65535));
                else
                    send_job(edf_pkg::ACT_TICK, $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(1, 65535));
            end
            phase++;
        end
    endtask

    // Fill the table, push past it, and make sure ticks and finish go on.
    task automatic test_table_overflow();
        write_day_limit(clip_day(int'(sched_day) + 50));
        while (sched_total < MAX_JOBS)
            load_near_job();
        repeat (3) load_near_job();
        repeat (4) send_job(edf_pkg::ACT_TICK, 0, 0, 1);
        send_job(edf_pkg::ACT_FINISH, 0, 0, 1);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.day_limit    = '0;
        job_if.valid        = 1'b0;
        job_if.action       = edf_pkg::ACT_LOAD;
        job_if.release_day  = '0;
        job_if.deadline_day = '0;
        job_if.duration     = '0;
        res_if.ready        = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_edf_order();
        test_missed_deadline();
        test_random_schedule();
        test_table_overflow();

        // Drain, then give the block time to show any stray result.
        settle_block(SETTLE_CYCLES);

        if (mismatch_count == 0 && slot_results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
